FILE: hw/rtl/mstv_pkg.sv
// shared types, constants and helpers of the tangent velocity unit
`default_nettype none
package mstv_pkg;

	// default number of fraction bits
	localparam int FRAC_BITS_DEF = 16;
	// steps of the square root pipe and quotient bits of the divider pipe
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE    = 3'd0,
		REG_VEC_A_X = 3'd1,
		REG_VEC_A_Y = 3'd2,
		REG_VEC_A_Z = 3'd3,
		REG_AXIS_X  = 3'd4,
		REG_AXIS_Y  = 3'd5,
		REG_AXIS_Z  = 3'd6,
		REG_OMEGA   = 3'd7
	} cfg_reg_t;

	// three signed fixed point components
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [64:0] hi;
		logic signed [64:0] lo;
		hi = 65'sd2147483647;
		lo = -65'sd2147483648;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// magnitude of a signed 32-bit value
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] u;
		u = v;
		return u[31] ? (~u + 32'd1) : u;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mesh_surface_tangent_velocity_unit.sv
// tangential wall velocity of mesh nodes, conveyor or rotating wall
//
// Input channel in_valid/in_ready carries one node beat: face normal and node
// position. Output channel out_valid/out_ready carries one velocity beat with
// the too_slow flag, in input order, one result per node.
// From input accept to out_valid a beat passes ten arithmetic stages, a 32-stage
// square root, one scaling multiply and a 33-stage divider.
// Throughput is one beat per clock while in_ready is high; a two-entry output
// buffer (output register plus skid register) lets the pipe keep accepting while
// a result waits. When the receiver stalls long enough to fill the skid
// register, the whole pipe freezes and in_ready drops; nothing is lost or repeated.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata while the block is
// empty. A write to any axis register starts the unit axis sequencer, which
// holds in_ready low while it sums the squares, takes the root and divides each
// component; it skips the divisions when all axis components are zero.
// Reset clears the pipe and buffers and loads the register reset values with
// the matching unit axis, so no sequencer pass follows reset.
`default_nettype none
module mesh_surface_tangent_velocity_unit import mstv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic signed [31:0]    normal_x,
	input  wire logic signed [31:0]    normal_y,
	input  wire logic signed [31:0]    normal_z,
	input  wire logic signed [31:0]    node_x,
	input  wire logic signed [31:0]    node_y,
	input  wire logic signed [31:0]    node_z,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [31:0]         vel_x,
	output logic signed [31:0]         vel_y,
	output logic signed [31:0]         vel_z,
	output logic                       too_slow
);

	localparam int NST      = 10 + SQRT_STEPS + 1 + DIV_STEPS + 1;
	localparam int MV_DLY   = 4;
	localparam int SLOW_DLY = NST - 6;
	localparam logic [63:0] SPEED_SQ_MIN =
		((64'd1 << (2 * FRAC_BITS)) + 64'd9999999999) / 64'd10000000000;

	// configuration registers
	logic               mode_q;
	logic signed [31:0] va_q [3];
	vec_t               axis_q;
	logic signed [31:0] omega_q;

	vec_t               u_vec;
	logic               ax_busy;
	logic               ax_start;
	logic signed [31:0] u [3];
	logic signed [32:0] neg_om;

	// pipe control
	logic [NST-1:0] vld_q;
	logic           adv;
	logic           push;

	// pipeline payload
	logic signed [31:0] n_in [3];
	logic signed [31:0] node_in [3];
	logic signed [31:0] n_s1 [3], n_s2 [3], n_s3 [3], n_s4 [3], n_s5 [3], n_s6 [3];
	logic signed [31:0] r_s1 [3];
	logic signed [63:0] xa_s2 [3], xb_s2 [3];
	logic signed [31:0] c_s3 [3];
	logic signed [63:0] cw [3];
	logic signed [31:0] v_s4 [3], v_s5 [3], v_s6 [3], v_s7 [3];
	logic        [63:0] sq_s5 [3];
	logic signed [63:0] vn_s5 [3];
	logic        [63:0] sumsq_s6;
	logic signed [31:0] scp_s6;
	logic               slow_s6;
	logic signed [63:0] pn_s7 [3];
	logic signed [31:0] d_s8 [3], d_s9 [3], d_s10 [3];
	logic        [63:0] dsq_s9 [3];
	logic        [63:0] sumd_s10;
	logic        [31:0] mv_root, mv_dl, md_root;
	logic        [95:0] d_dl;
	logic signed [31:0] d_al [3];
	logic        [63:0] pr_s43 [3];
	logic               neg_s43 [3];
	logic        [31:0] md_s43;
	logic signed [31:0] quo [3];
	logic               slow_dl;

	// output buffer
	logic               out_vld_q, skid_vld_q;
	logic signed [31:0] out_q [3], skid_q [3];
	logic               out_slow_q, skid_slow_q;

	assign n_in[0]    = normal_x;
	assign n_in[1]    = normal_y;
	assign n_in[2]    = normal_z;
	assign node_in[0] = node_x;
	assign node_in[1] = node_y;
	assign node_in[2] = node_z;
	assign u[0]       = u_vec.x;
	assign u[1]       = u_vec.y;
	assign u[2]       = u_vec.z;
	assign neg_om     = -33'(omega_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			va_q[0]  <= '0;
			va_q[1]  <= '0;
			va_q[2]  <= '0;
			axis_q.x <= '0;
			axis_q.y <= '0;
			axis_q.z <= 32'sd65536;
			omega_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_MODE:    mode_q   <= cfg_wdata[0];
				REG_VEC_A_X: va_q[0]  <= cfg_wdata;
				REG_VEC_A_Y: va_q[1]  <= cfg_wdata;
				REG_VEC_A_Z: va_q[2]  <= cfg_wdata;
				REG_AXIS_X:  axis_q.x <= cfg_wdata;
				REG_AXIS_Y:  axis_q.y <= cfg_wdata;
				REG_AXIS_Z:  axis_q.z <= cfg_wdata;
				REG_OMEGA:   omega_q  <= cfg_wdata;
				default:     mode_q   <= mode_q;
			endcase
		end
	end

	assign ax_start = cfg_we && (cfg_idx == REG_AXIS_X || cfg_idx == REG_AXIS_Y ||
		cfg_idx == REG_AXIS_Z);

	mstv_axis_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ax_start),
		.axis     (axis_q),
		.unit_axis(u_vec),
		.busy     (ax_busy)
	);

	// the pipe moves unless the skid register is holding a beat
	assign adv      = !skid_vld_q;
	assign in_ready = adv && !ax_busy;
	assign push     = adv && vld_q[NST-1];

	// valid bits travel alongside the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid && in_ready};
		end
	end

	// arithmetic stages 1 to 10
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				// lever arm
				n_s1[i] <= n_in[i];
				r_s1[i] <= sat32(65'(node_in[i]) - 65'(va_q[i]));
				n_s2[i] <= n_s1[i];
				n_s3[i] <= n_s2[i];
				// cross product terms and their difference
				c_s3[i] <= sat32((65'(xa_s2[i]) - 65'(xb_s2[i])) >>> FRAC_BITS);
				n_s4[i] <= n_s3[i];
				// scale by minus omega, pick the mode's vector
				v_s4[i] <= mode_q ? sat32(65'(cw[i] >>> FRAC_BITS)) : va_q[i];
				n_s5[i] <= n_s4[i];
				v_s5[i] <= v_s4[i];
				sq_s5[i] <= mag32(v_s4[i]) * mag32(v_s4[i]);
				vn_s5[i] <= v_s4[i] * n_s4[i];
				n_s6[i] <= n_s5[i];
				v_s6[i] <= v_s5[i];
				// normal times scalar product
				v_s7[i]  <= v_s6[i];
				pn_s7[i] <= n_s6[i] * scp_s6;
				// projected vector
				d_s8[i]  <= sat32(65'(v_s7[i]) - 65'(sat32(65'(pn_s7[i] >>> FRAC_BITS))));
				d_s9[i]  <= d_s8[i];
				dsq_s9[i] <= mag32(d_s8[i]) * mag32(d_s8[i]);
				d_s10[i] <= d_s9[i];
			end
			xa_s2[0] <= r_s1[1] * u[2];
			xb_s2[0] <= r_s1[2] * u[1];
			xa_s2[1] <= r_s1[2] * u[0];
			xb_s2[1] <= r_s1[0] * u[2];
			xa_s2[2] <= r_s1[0] * u[1];
			xb_s2[2] <= r_s1[1] * u[0];
			// magnitude squared, scalar product and speed check
			sumsq_s6 <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			scp_s6   <= sat32(65'(vn_s5[0] >>> FRAC_BITS) + 65'(vn_s5[1] >>> FRAC_BITS) +
				65'(vn_s5[2] >>> FRAC_BITS));
			slow_s6  <= mode_q && ((sq_s5[0] + sq_s5[1] + sq_s5[2]) < SPEED_SQ_MIN);
			sumd_s10 <= dsq_s9[0] + dsq_s9[1] + dsq_s9[2];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_omega
		assign cw[g] = c_s3[g] * neg_om;
	end

	// magnitude before projection, realigned to the projected magnitude
	mstv_isqrt_pipe u_sqrt_mv (
		.clk (clk),
		.en  (adv),
		.din (sumsq_s6),
		.dout(mv_root)
	);

	mstv_delay #(
		.W    (32),
		.DEPTH(MV_DLY)
	) u_dly_mv (
		.clk (clk),
		.en  (adv),
		.din (mv_root),
		.dout(mv_dl)
	);

	// magnitude after projection
	mstv_isqrt_pipe u_sqrt_md (
		.clk (clk),
		.en  (adv),
		.din (sumd_s10),
		.dout(md_root)
	);

	mstv_delay #(
		.W    (96),
		.DEPTH(SQRT_STEPS)
	) u_dly_d (
		.clk (clk),
		.en  (adv),
		.din ({d_s10[2], d_s10[1], d_s10[0]}),
		.dout(d_dl)
	);

	assign d_al[0] = d_dl[31:0];
	assign d_al[1] = d_dl[63:32];
	assign d_al[2] = d_dl[95:64];

	// rescale numerators
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pr_s43[i]  <= mag32(d_al[i]) * mv_dl;
				neg_s43[i] <= d_al[i][31];
			end
			md_s43 <= md_root;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		mstv_div_pipe u_div (
			.clk(clk),
			.en (adv),
			.num(pr_s43[g]),
			.den(md_s43),
			.neg(neg_s43[g]),
			.quo(quo[g])
		);
	end

	mstv_delay #(
		.W    (1),
		.DEPTH(SLOW_DLY)
	) u_dly_slow (
		.clk (clk),
		.en  (adv),
		.din (slow_s6),
		.dout(slow_dl)
	);

	// output register and skid register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			if (!out_vld_q || out_ready) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (out_ready) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output beat data
	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_vld_q || out_ready) begin
				out_q      <= quo;
				out_slow_q <= slow_dl;
			end else begin
				skid_q      <= quo;
				skid_slow_q <= slow_dl;
			end
		end else if (out_ready && skid_vld_q) begin
			out_q      <= skid_q;
			out_slow_q <= skid_slow_q;
		end
	end

	assign out_valid = out_vld_q;
	assign vel_x     = out_q[0];
	assign vel_y     = out_q[1];
	assign vel_z     = out_q[2];
	assign too_slow  = out_slow_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register holds a beat while the output register is empty");

	a_skid_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !in_ready)
		else $error("input taken while the skid register is full");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		ax_busy |-> !in_ready)
		else $error("input taken while the unit axis is being computed");

	a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted beat missing from the first stage");

endmodule
`default_nettype wire

FILE: hw/rtl/mstv_delay.sv
// enabled shift line that keeps side data in step with the pipeline
`default_nettype none
module mstv_delay #(
	parameter int W = 1,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] sh_q [DEPTH];

	// shift on every pipeline advance
	always_ff @(posedge clk) begin
		if (en) begin
			sh_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

	assign dout = sh_q[DEPTH-1];

endmodule
`default_nettype wire

FILE: hw/rtl/mstv_isqrt_pipe.sv
// pipelined integer square root of a 64-bit value, one result bit per stage
`default_nettype none
module mstv_isqrt_pipe import mstv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] din,
	output logic      [31:0] dout
);

	logic [63:0] rv_q  [SQRT_STEPS];
	logic [63:0] res_q [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
		logic [63:0] rv_in;
		logic [63:0] res_in;
		logic [63:0] trial;
		logic        take;

		if (k == 0) begin : g_first
			assign rv_in  = din;
			assign res_in = '0;
		end else begin : g_next
			assign rv_in  = rv_q[k-1];
			assign res_in = res_q[k-1];
		end

		// trial subtract of the next root bit
		assign trial = res_in + BIT;
		assign take  = (rv_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rv_q[k]  <= take ? (rv_in - trial) : rv_in;
				res_q[k] <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
			end
		end
	end

	assign dout = res_q[SQRT_STEPS-1][31:0];

endmodule
`default_nettype wire

FILE: hw/rtl/mstv_div_pipe.sv
// pipelined restoring divider with signed saturation of the quotient
`default_nettype none
module mstv_div_pipe import mstv_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [63:0] num,
	input  wire logic        [31:0] den,
	input  wire logic               neg,
	output logic signed      [31:0] quo
);

	logic [63:0] rem0_q;
	logic [31:0] den0_q;
	logic        neg0_q;
	logic        ovf0_q;
	logic        zero0_q;

	logic [63:0]          rem_q  [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_q    [DIV_STEPS];
	logic [31:0]          den_q  [DIV_STEPS];
	logic                 neg_q  [DIV_STEPS];
	logic                 ovf_q  [DIV_STEPS];
	logic                 zero_q [DIV_STEPS];

	logic [DIV_STEPS-1:0] q_fin;
	logic                 big;

	// entry stage: quotient overflow and zero divisor checks
	always_ff @(posedge clk) begin
		if (en) begin
			rem0_q  <= num;
			den0_q  <= den;
			neg0_q  <= neg;
			ovf0_q  <= (num >= (64'(den) << DIV_STEPS));
			zero0_q <= (den == 32'd0);
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int QB = DIV_STEPS - 1 - k;
		logic [63:0]          rem_in;
		logic [DIV_STEPS-1:0] q_in;
		logic [31:0]          den_in;
		logic                 neg_in;
		logic                 ovf_in;
		logic                 zero_in;
		logic [63:0]          dsh;
		logic                 take;

		if (k == 0) begin : g_first
			assign rem_in  = rem0_q;
			assign q_in    = '0;
			assign den_in  = den0_q;
			assign neg_in  = neg0_q;
			assign ovf_in  = ovf0_q;
			assign zero_in = zero0_q;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign q_in    = q_q[k-1];
			assign den_in  = den_q[k-1];
			assign neg_in  = neg_q[k-1];
			assign ovf_in  = ovf_q[k-1];
			assign zero_in = zero_q[k-1];
		end

		// one quotient bit, msb first
		assign dsh  = 64'(den_in) << QB;
		assign take = (rem_in >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= take ? (rem_in - dsh) : rem_in;
				q_q[k]    <= {q_in[DIV_STEPS-2:0], take};
				den_q[k]  <= den_in;
				neg_q[k]  <= neg_in;
				ovf_q[k]  <= ovf_in;
				zero_q[k] <= zero_in;
			end
		end
	end

	// apply sign and clamp to 32 bits
	assign q_fin = q_q[DIV_STEPS-1];
	assign big   = ovf_q[DIV_STEPS-1] | q_fin[DIV_STEPS-1];

	always_comb begin
		if (zero_q[DIV_STEPS-1]) begin
			quo = '0;
		end else if (neg_q[DIV_STEPS-1]) begin
			quo = big ? 32'sh8000_0000 : $signed(~q_fin + 32'd1);
		end else begin
			quo = big ? 32'sh7FFF_FFFF : $signed(q_fin);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/mstv_axis_unit.sv
// sequencer that turns the rotation axis into a unit axis after each axis write
`default_nettype none
module mstv_axis_unit import mstv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire vec_t axis,
	output vec_t      unit_axis,
	output logic      busy
);

	localparam int CNT_W = ($clog2(SQRT_STEPS) > $clog2(FRAC_BITS + 1)) ?
		$clog2(SQRT_STEPS) : $clog2(FRAC_BITS + 1);
	localparam logic [63:0] BIT_TOP = 64'd1 << (2 * SQRT_STEPS - 2);

	typedef enum logic [2:0] {
		AX_IDLE,
		AX_SUMSQ,
		AX_ROOT,
		AX_LOAD,
		AX_DIV
	} ax_state_t;

	ax_state_t          state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         comp_q;
	logic [63:0]        acc_q;
	logic [63:0]        res_q;
	logic [63:0]        bit_q;
	logic [31:0]        am_q;
	logic [63:0]        rem_q;
	logic [FRAC_BITS:0] quo_q;
	vec_t               u_q;

	logic signed [31:0] ax_sel;
	logic [31:0]        ax_mag;
	logic [63:0]        ax_sq;
	logic [63:0]        trial;
	logic               root_take;
	logic [63:0]        res_nx;
	logic [63:0]        dsh;
	logic               div_take;
	logic [FRAC_BITS:0] quo_nx;
	logic signed [31:0] u_val;

	// component select and one shared multiplier
	always_comb begin
		case (comp_q)
			2'd0:    ax_sel = axis.x;
			2'd1:    ax_sel = axis.y;
			default: ax_sel = axis.z;
		endcase
		ax_mag    = mag32(ax_sel);
		ax_sq     = ax_mag * ax_mag;
		trial     = res_q + bit_q;
		root_take = (acc_q >= trial);
		res_nx    = root_take ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		dsh       = 64'(am_q) << cnt_q;
		div_take  = (rem_q >= dsh);
		quo_nx    = {quo_q[FRAC_BITS-1:0], div_take};
		u_val     = ax_sel[31] ? -$signed(32'(quo_nx)) : $signed(32'(quo_nx));
	end

	// sum of squares, root, then one division per component when the root is not zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AX_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			acc_q   <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			am_q    <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			u_q.x   <= '0;
			u_q.y   <= '0;
			u_q.z   <= 32'(64'd1 << FRAC_BITS);
		end else if (start) begin
			state_q <= AX_SUMSQ;
			comp_q  <= '0;
			acc_q   <= '0;
		end else begin
			unique case (state_q)
				AX_IDLE: begin
				end
				AX_SUMSQ: begin
					acc_q <= acc_q + ax_sq;
					if (comp_q == 2'd2) begin
						state_q <= AX_ROOT;
						cnt_q   <= '0;
						res_q   <= '0;
						bit_q   <= BIT_TOP;
					end else begin
						comp_q <= comp_q + 2'd1;
					end
				end
				AX_ROOT: begin
					acc_q <= root_take ? (acc_q - trial) : acc_q;
					res_q <= res_nx;
					bit_q <= bit_q >> 2;
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
						am_q   <= res_nx[31:0];
						comp_q <= '0;
						if (res_nx == 64'd0) begin
							u_q     <= '0;
							state_q <= AX_IDLE;
						end else begin
							state_q <= AX_LOAD;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				AX_LOAD: begin
					rem_q   <= 64'(ax_mag) << FRAC_BITS;
					quo_q   <= '0;
					cnt_q   <= CNT_W'(FRAC_BITS);
					state_q <= AX_DIV;
				end
				AX_DIV: begin
					rem_q <= div_take ? (rem_q - dsh) : rem_q;
					quo_q <= quo_nx;
					if (cnt_q == '0) begin
						case (comp_q)
							2'd0:    u_q.x <= u_val;
							2'd1:    u_q.y <= u_val;
							default: u_q.z <= u_val;
						endcase
						if (comp_q == 2'd2) begin
							state_q <= AX_IDLE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= AX_LOAD;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= AX_IDLE;
				end
			endcase
		end
	end

	assign unit_axis = u_q;
	assign busy      = (state_q != AX_IDLE);

endmodule
`default_nettype wire
